// ===== sv/srp_pkg.sv =====
// srp_pkg: shared types and constants of the sparse run packer with region filter
// record kind codes, configuration register indexes and the record plan struct
// no dependencies
package srp_pkg;

  // record kinds on the result channel
  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_ELEMENT = 2'd1,
    KIND_FILL    = 2'd2,
    KIND_TERM    = 2'd3
  } kind_t;

  // configuration port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_REGION_START = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_SIZE  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT       = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NEW_RUN_GAP  = 4'd3;

  localparam logic [7:0] NEW_RUN_GAP_RESET = 8'd4;

  // at most this many low flag bits survive into the records
  localparam int FLAG_KEEP_MAX = 16;

  localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

  // records one entry causes, in emission order: leading record, element, terminator
  typedef struct packed {
    logic term;
    logic elem;
    logic pre;
    logic pre_is_fill;
  } rec_plan_t;

endpackage

// ===== sv/srp_decode.sv =====
// srp_decode: region test and run decision for one registered entry
// produces the record plan, fill length and next run state
// depends on srp_pkg
module srp_decode import srp_pkg::*; #(
  parameter int ADDR_WIDTH = 64,
  parameter int FLAG_WIDTH = 16
) (
  input  logic [ADDR_WIDTH-1:0] address,
  input  logic [FLAG_WIDTH-1:0] hit_flags,
  input  logic                  last,
  input  logic [ADDR_WIDTH-1:0] region_start,
  input  logic [ADDR_WIDTH-1:0] region_size,
  input  logic                  invert,
  input  logic [7:0]            new_run_gap,
  input  logic                  run_open,
  input  logic [ADDR_WIDTH-1:0] previous_address,
  input  logic [31:0]           kept_matches,
  output rec_plan_t             plan,
  output logic [7:0]            fill_gap,
  output logic [FLAG_WIDTH-1:0] flags_kept,
  output logic [31:0]           count_out,
  output logic                  run_open_next,
  output logic [ADDR_WIDTH-1:0] previous_address_next,
  output logic [31:0]           kept_matches_next
);

  localparam int FLAG_KEEP = (FLAG_WIDTH < FLAG_KEEP_MAX) ? FLAG_WIDTH : FLAG_KEEP_MAX;
  localparam logic [FLAG_WIDTH-1:0] FLAG_MASK = {FLAG_WIDTH{1'b1}} >> (FLAG_WIDTH - FLAG_KEEP);

  logic [ADDR_WIDTH-1:0] offset;
  logic                  in_window;
  logic                  keep;
  logic [ADDR_WIDTH-1:0] gap;
  logic [7:0]            limit;
  logic                  gap_big;
  logic                  new_run;
  logic [31:0]           kept_after;

  // region test, no wrap at the top
  assign offset    = address - region_start;
  assign in_window = (address >= region_start) && (offset < region_size);
  assign keep      = in_window ? invert : !invert;

  // skipped addresses since the previous kept entry
  assign gap     = address - previous_address - {{(ADDR_WIDTH-1){1'b0}}, 1'b1};
  assign limit   = (new_run_gap == 8'd0) ? 8'd1 : new_run_gap;
  assign gap_big = (|gap[ADDR_WIDTH-1:8]) || (gap[7:0] >= limit);
  assign new_run = !run_open || (address <= previous_address) || gap_big;

  assign flags_kept = hit_flags & FLAG_MASK;
  assign fill_gap   = gap[7:0];

  // saturating count of kept real matches
  always_comb begin
    kept_after = kept_matches;
    if (keep && (flags_kept != '0) && (kept_matches != COUNT_MAX)) begin
      kept_after = kept_matches + 32'd1;
    end
  end

  assign count_out = kept_after;

  // which records this entry causes
  always_comb begin
    plan.term        = last;
    plan.elem        = keep;
    plan.pre         = keep && (new_run || (gap[7:0] != 8'd0));
    plan.pre_is_fill = !new_run;
  end

  // run state after this entry, cleared at the end of a pass
  always_comb begin
    run_open_next         = run_open;
    previous_address_next = previous_address;
    kept_matches_next     = kept_after;
    if (keep) begin
      run_open_next         = 1'b1;
      previous_address_next = address;
    end
    if (last) begin
      run_open_next         = 1'b0;
      previous_address_next = '0;
      kept_matches_next     = '0;
    end
  end

endmodule

// ===== sv/srp_emit.sv =====
// srp_emit: record buffer that holds the records of one entry and sends them
// one per transfer, leading record first and terminator last
// depends on srp_pkg
module srp_emit import srp_pkg::*; #(
  parameter int ADDR_WIDTH = 64,
  parameter int FLAG_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  rec_plan_t             plan,
  input  logic [ADDR_WIDTH-1:0] address,
  input  logic [7:0]            fill_gap,
  input  logic [7:0]            prior_byte,
  input  logic [FLAG_WIDTH-1:0] flags_kept,
  input  logic [31:0]           count_in,
  output logic                  free,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            record_kind,
  output logic [ADDR_WIDTH-1:0] run_address,
  output logic [7:0]            fill_count,
  output logic [7:0]            value_out,
  output logic [FLAG_WIDTH-1:0] flags_out,
  output logic [31:0]           match_count,
  output logic                  end_of_run
);

  // pending slots: bit 0 leading record, bit 1 element, bit 2 terminator
  logic [2:0]            pend;
  logic [2:0]            pend_next;
  logic [2:0]            rest;
  logic                  pre_is_fill;
  logic [ADDR_WIDTH-1:0] addr_q;
  logic [7:0]            gap_q;
  logic [7:0]            value_q;
  logic [FLAG_WIDTH-1:0] flags_q;
  logic [31:0]           count_q;
  logic                  take;

  assign out_valid = |pend;
  assign take      = out_valid && out_ready;
  assign rest      = pend & (pend - 3'd1);
  assign free      = !out_valid || (take && (rest == 3'd0));
  assign end_of_run = (rest == 3'd0);

  always_comb begin
    pend_next = pend;
    if (take) begin
      pend_next = rest;
    end
    if (load) begin
      pend_next = {plan.term, plan.elem, plan.pre};
    end
  end

  // control and payload of the buffered entry
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 3'd0;
    end else begin
      pend <= pend_next;
    end
    if (load) begin
      pre_is_fill <= plan.pre_is_fill;
      addr_q      <= address;
      gap_q       <= fill_gap;
      value_q     <= prior_byte;
      flags_q     <= flags_kept;
      count_q     <= count_in;
    end
  end

  // current record fields
  always_comb begin
    record_kind = KIND_TERM;
    run_address = '0;
    fill_count  = 8'd0;
    value_out   = 8'd0;
    flags_out   = '0;
    match_count = 32'd0;
    priority if (pend[0]) begin
      record_kind = pre_is_fill ? KIND_FILL : KIND_HEADER;
      run_address = addr_q;
      fill_count  = pre_is_fill ? gap_q : 8'd0;
    end else if (pend[1]) begin
      record_kind = KIND_ELEMENT;
      run_address = addr_q;
      value_out   = value_q;
      flags_out   = flags_q;
    end else begin
      record_kind = KIND_TERM;
      match_count = count_q;
    end
  end

endmodule

// ===== sv/sparse_run_packer_region_filter.sv =====
// sparse_run_packer_region_filter: top level of the region filter and run packer
// holds configuration, input register and run state; uses srp_decode and srp_emit
// depends on srp_pkg
//
// Usage
//   Input channel (in_valid/in_ready) takes match entries: address, prior_byte,
//   hit_flags and last. Output channel (out_valid/out_ready) gives records:
//   run header, element, zero fill or terminator, with end_of_run on the last
//   record an entry causes. Configuration is written through cfg_write,
//   cfg_index and cfg_data; the user must do so only while the block is
//   idle, which the block itself does not enforce.
//   Path: an accepted entry waits in the input register, is decoded there and
//   is loaded into the record buffer once that buffer is free.
//   Throughput: one record per cycle while out_ready is high. The record buffer
//   takes the next entry when the last record of the current one transfers, so
//   an entry causing two or three records holds the input while the buffer
//   sends them one per transfer; an entry causing none is passed straight over.
//   Reset: synchronous, clears the input register, record buffer and run state
//   and loads register defaults (new_run_gap 4, others 0).
//   Stall: when out_ready is low the buffered records hold; one further entry
//   waits in the input register, then in_ready drops.
module sparse_run_packer_region_filter import srp_pkg::*; #(
  parameter int ADDR_WIDTH = 64,
  parameter int FLAG_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [ADDR_WIDTH-1:0] address,
  input  logic [7:0]            prior_byte,
  input  logic [FLAG_WIDTH-1:0] hit_flags,
  input  logic                  last,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            record_kind,
  output logic [ADDR_WIDTH-1:0] run_address,
  output logic [7:0]            fill_count,
  output logic [7:0]            value_out,
  output logic [FLAG_WIDTH-1:0] flags_out,
  output logic [31:0]           match_count,
  output logic                  end_of_run
);

  // configuration registers
  logic [ADDR_WIDTH-1:0] region_start;
  logic [ADDR_WIDTH-1:0] region_size;
  logic                  invert;
  logic [7:0]            new_run_gap;

  // input register
  logic                  a_valid;
  logic [ADDR_WIDTH-1:0] a_address;
  logic [7:0]            a_value;
  logic [FLAG_WIDTH-1:0] a_flags;
  logic                  a_last;

  // run state
  logic                  run_open;
  logic [ADDR_WIDTH-1:0] previous_address;
  logic [31:0]           kept_matches;
  logic                  run_open_next;
  logic [ADDR_WIDTH-1:0] previous_address_next;
  logic [31:0]           kept_matches_next;

  rec_plan_t             plan;
  logic [7:0]            fill_gap;
  logic [FLAG_WIDTH-1:0] flags_kept;
  logic [31:0]           count_out;
  logic                  plan_empty;
  logic                  emit_free;
  logic                  a_take;
  logic                  load;

  assign plan_empty = !(plan.pre || plan.elem || plan.term);
  assign a_take     = a_valid && (plan_empty || emit_free);
  assign load       = a_take && !plan_empty;
  assign in_ready   = !a_valid || a_take;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      region_start <= '0;
      region_size  <= '0;
      invert       <= 1'b0;
      new_run_gap  <= NEW_RUN_GAP_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_REGION_START: region_start <= cfg_data[ADDR_WIDTH-1:0];
        CFG_REGION_SIZE:  region_size  <= cfg_data[ADDR_WIDTH-1:0];
        CFG_INVERT:       invert       <= cfg_data[0];
        CFG_NEW_RUN_GAP:  new_run_gap  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // input register, refilled on each input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_ready) begin
      a_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      a_address <= address;
      a_value   <= prior_byte;
      a_flags   <= hit_flags;
      a_last    <= last;
    end
  end

  // run state advances as each entry leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      run_open         <= 1'b0;
      previous_address <= '0;
      kept_matches     <= '0;
    end else if (a_take) begin
      run_open         <= run_open_next;
      previous_address <= previous_address_next;
      kept_matches     <= kept_matches_next;
    end
  end

  srp_decode #(
    .ADDR_WIDTH(ADDR_WIDTH),
    .FLAG_WIDTH(FLAG_WIDTH)
  ) u_decode (
    .address              (a_address),
    .hit_flags            (a_flags),
    .last                 (a_last),
    .region_start         (region_start),
    .region_size          (region_size),
    .invert               (invert),
    .new_run_gap          (new_run_gap),
    .run_open             (run_open),
    .previous_address     (previous_address),
    .kept_matches         (kept_matches),
    .plan                 (plan),
    .fill_gap             (fill_gap),
    .flags_kept           (flags_kept),
    .count_out            (count_out),
    .run_open_next        (run_open_next),
    .previous_address_next(previous_address_next),
    .kept_matches_next    (kept_matches_next)
  );

  srp_emit #(
    .ADDR_WIDTH(ADDR_WIDTH),
    .FLAG_WIDTH(FLAG_WIDTH)
  ) u_emit (
    .clk        (clk),
    .rst        (rst),
    .load       (load),
    .plan       (plan),
    .address    (a_address),
    .fill_gap   (fill_gap),
    .prior_byte (a_value),
    .flags_kept (flags_kept),
    .count_in   (count_out),
    .free       (emit_free),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .record_kind(record_kind),
    .run_address(run_address),
    .fill_count (fill_count),
    .value_out  (value_out),
    .flags_out  (flags_out),
    .match_count(match_count),
    .end_of_run (end_of_run)
  );

endmodule

// ===== dv/tb_sparse_run_packer_region_filter.sv =====
`timescale 1ns / 1ps
// tb_sparse_run_packer_region_filter: self-checking bench for the region filter and run packer
// predicts the record stream per entry and checks every output transfer in order
// depends on srp_pkg and sparse_run_packer_region_filter
module tb_sparse_run_packer_region_filter;
  import srp_pkg::*;

  localparam int AW = 64;
  localparam int FW = 16;
  // cycles after the last record before the block counts as idle
  localparam int SETTLE = 5;

  typedef struct {
    kind_t          kind;
    logic [AW-1:0]  addr;
    logic [7:0]     fill;
    logic [7:0]     value;
    logic [FW-1:0]  flags;
    logic [31:0]    count;
    logic           eor;
  } record_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic [AW-1:0]         address;
  logic [7:0]            prior_byte;
  logic [FW-1:0]         hit_flags;
  logic                  last;
  logic                  out_valid;
  logic                  out_ready;
  logic [1:0]            record_kind;
  logic [AW-1:0]         run_address;
  logic [7:0]            fill_count;
  logic [7:0]            value_out;
  logic [FW-1:0]         flags_out;
  logic [31:0]           match_count;
  logic                  end_of_run;

  // predictor copy of configuration and run state
  logic [AW-1:0] region_start_q = '0;
  logic [AW-1:0] region_size_q  = '0;
  logic          invert_q       = 1'b0;
  logic [7:0]    run_gap_q      = NEW_RUN_GAP_RESET;
  logic          run_open_q     = 1'b0;
  logic [AW-1:0] prev_addr_q    = '0;
  logic [31:0]   match_total_q  = '0;

  record_t pending_records[$];
  int      errors     = 0;
  int      productive = 0;
  bit      tx_idle    = 1'b1;
  bit      rx_idle    = 1'b1;
  int      rx_hold    = 0;

  sparse_run_packer_region_filter #(
    .ADDR_WIDTH (AW),
    .FLAG_WIDTH (FW)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .address     (address),
    .prior_byte  (prior_byte),
    .hit_flags   (hit_flags),
    .last        (last),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .record_kind (record_kind),
    .run_address (run_address),
    .fill_count  (fill_count),
    .value_out   (value_out),
    .flags_out   (flags_out),
    .match_count (match_count),
    .end_of_run  (end_of_run)
  );

  // clock, 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic record_t make_record(kind_t k, logic [AW-1:0] a, logic [7:0] fc,
                                          logic [7:0] v, logic [FW-1:0] f, logic [31:0] c);
    record_t r;
    r.kind  = k;
    r.addr  = a;
    r.fill  = fc;
    r.value = v;
    r.flags = f;
    r.count = c;
    r.eor   = 1'b0;
    return r;
  endfunction

  // region test, run packing and pass end for one accepted entry
  task automatic pack_entry(input logic [AW-1:0] a, input logic [7:0] v,
                            input logic [FW-1:0] f, input logic l);
    record_t       recs[$];
    logic          in_window;
    logic          keep;
    logic [AW-1:0] gap;
    logic [7:0]    limit;
    in_window = (a >= region_start_q) && ((a - region_start_q) < region_size_q);
    keep = in_window ? invert_q : !invert_q;
    if (keep) begin
      if (!run_open_q || a <= prev_addr_q) begin
        recs.push_back(make_record(KIND_HEADER, a, 8'd0, 8'd0, '0, 32'd0));
      end else begin
        gap = a - prev_addr_q - AW'(1);
        limit = (run_gap_q == 8'd0) ? 8'd1 : run_gap_q;
        if (gap >= AW'(limit)) begin
          recs.push_back(make_record(KIND_HEADER, a, 8'd0, 8'd0, '0, 32'd0));
        end else if (gap != '0) begin
          recs.push_back(make_record(KIND_FILL, a, gap[7:0], 8'd0, '0, 32'd0));
        end
      end
      recs.push_back(make_record(KIND_ELEMENT, a, 8'd0, v, f, 32'd0));
      run_open_q = 1'b1;
      prev_addr_q = a;
      if (f != '0 && match_total_q != COUNT_MAX) match_total_q = match_total_q + 32'd1;
    end
    // terminator closes the pass and clears run state
    if (l) begin
      recs.push_back(make_record(KIND_TERM, '0, 8'd0, 8'd0, '0, match_total_q));
      run_open_q = 1'b0;
      prev_addr_q = '0;
      match_total_q = '0;
    end
    if (recs.size() != 0) begin
      recs[recs.size()-1].eor = 1'b1;
      productive++;
    end
    foreach (recs[i]) pending_records.push_back(recs[i]);
  endtask

  // offer one entry after a random gap, return at its transfer edge
  task automatic send_entry(input logic [AW-1:0] a, input logic [7:0] v,
                            input logic [FW-1:0] f, input logic l);
    int idle_cycles;
    idle_cycles = tx_idle ? int'($urandom_range(0, 12)) : 0;
    @(negedge clk);
    if (idle_cycles != 0) begin
      in_valid = 1'b0;
      repeat (idle_cycles) @(negedge clk);
    end
    address    = a;
    prior_byte = v;
    hit_flags  = f;
    last       = l;
    in_valid   = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pack_entry(a, v, f, l);
  endtask

  // stop offering and wait until every predicted record has come out
  task automatic wait_idle();
    int waited;
    waited = 0;
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_records.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    if (pending_records.size() != 0) begin
      $error("%0d expected records never arrived", pending_records.size());
      errors++;
      pending_records.delete();
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_write = 1'b0;
    case (idx)
      CFG_REGION_START: region_start_q = data[AW-1:0];
      CFG_REGION_SIZE:  region_size_q  = data[AW-1:0];
      CFG_INVERT:       invert_q       = data[0];
      CFG_NEW_RUN_GAP:  run_gap_q      = data[7:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [AW-1:0] start, input logic [AW-1:0] size,
                            input logic inv, input logic [7:0] gap);
    wait_idle();
    write_reg(CFG_REGION_START, CFG_DATA_W'(start));
    write_reg(CFG_REGION_SIZE, CFG_DATA_W'(size));
    write_reg(CFG_INVERT, CFG_DATA_W'(inv));
    write_reg(CFG_NEW_RUN_GAP, CFG_DATA_W'(gap));
  endtask

  // reset settings keep everything: consecutive, fill, long gap, repeat, backward, top address
  task automatic test_run_shapes();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    send_entry(64'd0, 8'h00, 16'h0000, 1'b0);
    send_entry(64'd1, 8'hFF, 16'hFFFF, 1'b0);
    send_entry(64'd3, 8'h12, 16'h0001, 1'b0);
    send_entry(64'd7, 8'h34, 16'h0000, 1'b0);
    send_entry(64'd12, 8'h56, 16'h8000, 1'b0);
    send_entry(64'd12, 8'h78, 16'h00F0, 1'b0);
    send_entry(64'd5, 8'h9A, 16'h0000, 1'b0);
    send_entry(64'hFFFF_FFFF_FFFF_FFFF, 8'h5A, 16'h8001, 1'b1);
    // next pass starts from cleared state
    send_entry(64'd8, 8'hA5, 16'h0000, 1'b1);
    wait_idle();
  endtask

  // region bounds, inversion, region at the top, zero gap limit, widest fill
  task automatic test_region_edges();
    set_config(64'd100, 64'd50, 1'b1, 8'd4);
    send_entry(64'd99, 8'h01, 16'h0101, 1'b0);
    send_entry(64'd100, 8'h02, 16'h0202, 1'b0);
    send_entry(64'd149, 8'h03, 16'h0303, 1'b0);
    send_entry(64'd150, 8'h04, 16'h0404, 1'b1);
    set_config(64'hFFFF_FFFF_FFFF_FFF0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 8'd0);
    send_entry(64'd0, 8'h11, 16'h0001, 1'b0);
    send_entry(64'd2, 8'h22, 16'h0002, 1'b0);
    send_entry(64'd3, 8'h33, 16'h0000, 1'b0);
    send_entry(64'hFFFF_FFFF_FFFF_FFF0, 8'h44, 16'h0004, 1'b0);
    send_entry(64'hFFFF_FFFF_FFFF_FFFF, 8'h55, 16'h0005, 1'b1);
    // empty region kept inside: every entry dropped, terminator only
    set_config(64'd0, 64'd0, 1'b1, 8'd255);
    send_entry({$urandom, $urandom}, 8'h66, 16'h0006, 1'b1);
    wait_idle();
    write_reg(CFG_INVERT, '0);
    send_entry(64'd1000, 8'h77, 16'h0007, 1'b0);
    send_entry(64'd1255, 8'h88, 16'h0008, 1'b0);
    send_entry(64'd1511, 8'h99, 16'h0009, 1'b1);
    wait_idle();
  endtask

  // random passes around the region, with noise and unterminated passes mixed in
  task automatic run_random_passes(input int target);
    int            goal;
    int            pass_len;
    int            step_kind;
    int            lim;
    logic [AW-1:0] a;
    logic [FW-1:0] f;
    logic          broken;
    goal = productive + target;
    while (productive < goal) begin
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 7) == 0) begin
        send_entry({$urandom, $urandom}, 8'($urandom_range(0, 255)),
                   FW'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
      end else begin
        pass_len = int'($urandom_range(1, 16));
        broken = ($urandom_range(0, 7) == 0);
        lim = (run_gap_q == 8'd0) ? 1 : int'(run_gap_q);
        a = region_start_q + AW'($urandom_range(0, 600)) - AW'(300);
        for (int i = 0; i < pass_len; i++) begin
          step_kind = int'($urandom_range(0, 19));
          // step 0 repeats the address
          if (i != 0) begin
            if (step_kind == 1) begin
              a = a - AW'($urandom_range(1, 8));
            end else if (step_kind == 2 || step_kind == 3) begin
              a = a + AW'(lim + 1 + int'($urandom_range(0, 3)));
            end else if (step_kind >= 4) begin
              a = a + AW'(1 + int'($urandom_range(0, lim)));
            end
          end
          f = ($urandom_range(0, 3) == 0) ? '0 : FW'($urandom_range(0, 65535));
          send_entry(a, 8'($urandom_range(0, 255)), f, (i == pass_len - 1) && !broken);
        end
      end
    end
  endtask

  task automatic test_random_mix();
    set_config({$urandom, $urandom}, AW'($urandom_range(64, 1024)), 1'b1, 8'd4);
    run_random_passes(40);
    set_config({$urandom, $urandom}, {$urandom, $urandom}, 1'b0, 8'd1);
    run_random_passes(40);
    set_config(64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 8'd255);
    run_random_passes(40);
    set_config(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 8'd0);
    run_random_passes(40);
    set_config({$urandom, $urandom}, 64'd0, 1'b0, 8'($urandom_range(1, 255)));
    run_random_passes(40);
    wait_idle();
  endtask

  // receiver holds off while entries keep coming, so the input stalls
  task automatic test_output_backpressure();
    logic [AW-1:0] a;
    set_config(64'd0, 64'd0, 1'b0, 8'd4);
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    rx_hold = 150;
    a = {$urandom, $urandom};
    for (int i = 0; i < 12; i++) begin
      a = a + AW'(1 + int'($urandom_range(0, 5)));
      send_entry(a, 8'($urandom_range(0, 255)), FW'($urandom_range(0, 65535)), i == 11);
    end
    wait_idle();
  endtask

  // sender pauses mid pass until all records are out, then finishes the pass
  task automatic test_sender_pause();
    logic [AW-1:0] a;
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    a = {$urandom, $urandom};
    for (int i = 0; i < 12; i++) begin
      if (i == 6) wait_idle();
      a = a + AW'(1 + int'($urandom_range(0, 5)));
      send_entry(a, 8'($urandom_range(0, 255)), FW'($urandom_range(0, 65535)), i == 11);
    end
    wait_idle();
  endtask

  // receiver: random stall per record, plus a long hold-off when asked
  initial begin
    int stall;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold != 0) begin
        out_ready = 1'b0;
        repeat (rx_hold) @(negedge clk);
        rx_hold = 0;
      end
      stall = rx_idle ? int'($urandom_range(0, 12)) : 0;
      if (stall != 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // compare each output transfer with the oldest predicted record
  always @(posedge clk) begin
    record_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_records.size() == 0) begin
        $error("unexpected record: kind %0d address %h", record_kind, run_address);
        errors++;
      end else begin
        want = pending_records.pop_front();
        if (record_kind !== want.kind) begin
          $error("record_kind: expected %0d, got %0d", want.kind, record_kind);
          errors++;
        end
        if (run_address !== want.addr) begin
          $error("run_address: expected %h, got %h", want.addr, run_address);
          errors++;
        end
        if (fill_count !== want.fill) begin
          $error("fill_count: expected %0d, got %0d", want.fill, fill_count);
          errors++;
        end
        if (value_out !== want.value) begin
          $error("value_out: expected %h, got %h", want.value, value_out);
          errors++;
        end
        if (flags_out !== want.flags) begin
          $error("flags_out: expected %h, got %h", want.flags, flags_out);
          errors++;
        end
        if (match_count !== want.count) begin
          $error("match_count: expected %0d, got %0d", want.count, match_count);
          errors++;
        end
        if (end_of_run !== want.eor) begin
          $error("end_of_run: expected %0d, got %0d", want.eor, end_of_run);
          errors++;
        end
      end
    end
  end

  // test sequence
  initial begin
    rst        = 1'b1;
    cfg_write  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    in_valid   = 1'b0;
    address    = '0;
    prior_byte = '0;
    hit_flags  = '0;
    last       = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_run_shapes();
    test_region_edges();
    test_random_mix();
    test_output_backpressure();
    test_sender_pause();
    wait_idle();
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== sparse_run_packer_region_filter.f =====
sv/srp_pkg.sv
sv/srp_decode.sv
sv/srp_emit.sv
sv/sparse_run_packer_region_filter.sv
dv/tb_sparse_run_packer_region_filter.sv
